// ===== rtl/scpu_pkg.sv =====
// ============================================================================
// scpu_pkg - shared types and constants of the stack CPU step engine
// Sizes, opcodes, port indices, state encoding and divider handshake.
// ============================================================================
package scpu_pkg;

  // Sizes
  localparam int unsigned IMAGE_WORDS  = 4096;
  localparam int unsigned PM_AW        = 12;
  localparam int unsigned IP_W         = 13;
  localparam int unsigned DATA_DEPTH   = 128;
  localparam int unsigned DP_W         = 7;
  localparam int unsigned RETURN_DEPTH = 1024;
  localparam int unsigned RP_W         = 10;
  localparam int unsigned PORT_COUNT   = 16;
  localparam int unsigned PORT_AW      = 4;

  typedef logic [31:0] word_t;

  // Host item kinds
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_EXEC   = 2'd1,
    KIND_PWRITE = 2'd2,
    KIND_PREAD  = 2'd3
  } kind_t;

  // Instruction set
  typedef enum logic [4:0] {
    OP_NOP, OP_LIT, OP_DUP, OP_DROP, OP_SWAP, OP_PUSH, OP_POP, OP_CALL,
    OP_JUMP, OP_RETURN, OP_GT_JUMP, OP_LT_JUMP, OP_NE_JUMP, OP_EQ_JUMP,
    OP_FETCH, OP_STORE, OP_ADD, OP_SUB, OP_MUL, OP_DIVMOD, OP_AND, OP_OR,
    OP_XOR, OP_SHL, OP_SHR, OP_ZERO_EXIT, OP_INC, OP_DEC, OP_IN, OP_OUT,
    OP_WAIT
  } op_t;

  localparam logic [4:0] OP_LAST = 5'd30;

  // Port cells with a fixed meaning for WAIT
  localparam int unsigned PORT_CTRL  = 0;
  localparam int unsigned PORT_KEY   = 1;
  localparam int unsigned PORT_CHAR  = 2;
  localparam int unsigned PORT_SAVE  = 4;
  localparam int unsigned PORT_QUERY = 5;

  // Capability query codes
  localparam word_t QRY_IMAGE = 32'hFFFF_FFFF;
  localparam word_t QRY_NONE2 = 32'hFFFF_FFFE;
  localparam word_t QRY_NONE3 = 32'hFFFF_FFFD;
  localparam word_t QRY_NONE4 = 32'hFFFF_FFFC;
  localparam word_t QRY_DEPTH = 32'hFFFF_FFFB;
  localparam word_t QRY_RDEPTH = 32'hFFFF_FFFA;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OPND,
    ST_EXEC,
    ST_DIV
  } state_t;

  // Divider handshake
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
    word_t rem;
  } div_rsp_t;

endpackage

// ===== rtl/scpu_ram.sv =====
// ============================================================================
// scpu_ram - single-port-write, single-port-read synchronous RAM
// Registered read data.
// ============================================================================
module scpu_ram #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scpu_dstack.sv =====
// ============================================================================
// scpu_dstack - data stack memory
// Synchronous RAM with a valid bit per entry; unwritten entries read zero.
// ============================================================================
module scpu_dstack (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    we,
  input  logic [scpu_pkg::DP_W-1:0] waddr,
  input  scpu_pkg::word_t         wdata,
  input  logic [scpu_pkg::DP_W-1:0] raddr,
  output scpu_pkg::word_t         rdata
);
  import scpu_pkg::*;

  word_t                 mem [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] vld_r;
  word_t                 rd_r;
  logic                  rd_vld_r;

  // storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

// ===== rtl/scpu_div.sv =====
// ============================================================================
// scpu_div - iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ============================================================================
module scpu_div (
  input  logic               clk,
  input  logic               rst_n,
  input  scpu_pkg::div_req_t req,
  output scpu_pkg::div_rsp_t rsp
);
  import scpu_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  word_t       q_r, q_nxt;
  word_t       r_r, r_nxt;
  word_t       b_r, b_nxt;
  logic        qneg_r, qneg_nxt;
  logic        rneg_r, rneg_nxt;
  logic [32:0] r_sh;
  logic [33:0] diff;

  // one restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    r_sh     = {r_r, q_r[31]};
    diff     = {1'b0, r_sh} - {2'b00, b_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      q_nxt    = req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
      b_nxt    = req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
      r_nxt    = '0;
      qneg_nxt = req.dividend[31] ^ req.divisor[31];
      rneg_nxt = req.dividend[31];
    end else if (busy_r) begin
      r_nxt   = diff[33] ? r_sh[31:0] : diff[31:0];
      q_nxt   = {q_r[30:0], ~diff[33]};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    b_r    <= b_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  // sign fix-up
  assign rsp.done = done_r;
  assign rsp.quot = qneg_r ? (~q_r + 32'd1) : q_r;
  assign rsp.rem  = rneg_r ? (~r_r + 32'd1) : r_r;

endmodule

// ===== rtl/stack_cpu_instruction_step.sv =====
// ============================================================================
// stack_cpu_instruction_step - dual-stack CPU core, one host item at a time
// Program memory, data stack, return stack and port cells behind a
// start/busy command port with a strobed result.
// ============================================================================
// Usage:
//   An item (in_opcode, in_address, in_value) transfers on a clock edge with
//   start high and busy low. in_opcode selects program word load, execute
//   one instruction, port write or port read.
//   Each item gives one result, shown for one cycle with out_valid high; the
//   receiver must take it then, it cannot stall the core.
//   Load, port write, port read and execute while halted strobe their result
//   straight from the idle state; execute runs through ST_OPND and ST_EXEC,
//   and DIVMOD with a non-zero divisor also waits in ST_DIV for the divider.
//   Execute is bound by the program memory read port: opcode read, then
//   operand read, then write-back; DIVMOD by the bit-serial divider.
//   busy is high from the accept edge of an execute on a running core until
//   its result strobe; other items leave it low, so the next transfer may
//   overlap the strobe. Reset: synchronous, active low. After reset the
//   return stack is swept to zero, one entry a cycle, with busy high. Program
//   memory is not cleared and must be loaded before it is executed.
// ============================================================================
module stack_cpu_instruction_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_opcode,
  input  logic [11:0]               in_address,
  input  logic signed [31:0]        in_value,
  output logic                      out_valid,
  output logic signed [31:0]        out_read_value,
  output logic [12:0]               out_instr_pointer,
  output logic                      out_halted,
  output logic [6:0]                out_data_depth,
  output logic [9:0]                out_return_depth,
  output logic                      out_io_request
);
  import scpu_pkg::*;

  // architectural state
  state_t           state_r, state_nxt;
  logic [IP_W-1:0]  ip_r, ip_nxt;
  word_t            top_r, top_nxt;
  logic [DP_W-1:0]  dp_r, dp_nxt;
  logic [RP_W-1:0]  rp_r, rp_nxt;
  logic             stopped_r, stopped_nxt;
  word_t            port_r [PORT_COUNT];
  word_t            port_nxt [PORT_COUNT];
  logic [RP_W-1:0]  clr_r, clr_nxt;

  // per-instruction latches
  logic [4:0]       op_r, op_nxt;
  logic             op_bad_r, op_bad_nxt;
  word_t            nos_r, nos_nxt;
  word_t            rtop_r, rtop_nxt;
  logic             opnd_ok_r, opnd_ok_nxt;

  // result registers
  logic             strobe_r, strobe_nxt;
  word_t            rv_r, rv_nxt;
  logic             req_r, req_nxt;

  // memory ports
  logic             pm_we;
  logic [PM_AW-1:0] pm_waddr, pm_raddr;
  word_t            pm_wdata, pm_rdata;
  logic             ds_we;
  logic [DP_W-1:0]  ds_waddr, ds_raddr;
  word_t            ds_wdata, ds_rdata;
  logic             rs_we;
  logic [RP_W-1:0]  rs_waddr, rs_raddr;
  word_t            rs_wdata, rs_rdata;

  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // datapath helpers
  logic             acc;
  word_t            ip_p1, ip_p2, operand, tgt;
  logic             jmp, take;
  logic [DP_W-1:0]  dp_inc, dp_dec, dp_dec2;
  logic [RP_W-1:0]  rp_inc, rp_dec;
  logic             top_in_ports, top_in_image, in_in_ports;
  logic [PORT_AW-1:0] top_pidx, in_pidx;
  logic             wait_busy;

  assign busy    = (state_r != ST_IDLE);
  assign acc     = start && !busy;
  assign ip_p1   = {{(32-IP_W){1'b0}}, ip_r} + 32'd1;
  assign ip_p2   = {{(32-IP_W){1'b0}}, ip_r} + 32'd2;
  assign operand = opnd_ok_r ? pm_rdata : '0;
  assign dp_inc  = dp_r + DP_W'(1);
  assign dp_dec  = dp_r - DP_W'(1);
  assign dp_dec2 = dp_r - DP_W'(2);
  assign rp_inc  = rp_r + RP_W'(1);
  assign rp_dec  = rp_r - RP_W'(1);
  assign top_in_ports = (top_r < PORT_COUNT);
  assign top_in_image = (top_r < IMAGE_WORDS);
  assign in_in_ports  = (in_address < 12'(PORT_COUNT));
  assign top_pidx = top_r[PORT_AW-1:0];
  assign in_pidx  = in_address[PORT_AW-1:0];
  assign wait_busy = (port_r[PORT_CTRL] == 32'd1);

  // ---------------------------------------------------------------------
  // sequencer: next state, memory control, read-modify-write of state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    ip_nxt      = ip_r;
    top_nxt     = top_r;
    dp_nxt      = dp_r;
    rp_nxt      = rp_r;
    stopped_nxt = stopped_r;
    port_nxt    = port_r;
    clr_nxt     = clr_r;
    op_nxt      = op_r;
    op_bad_nxt  = op_bad_r;
    nos_nxt     = nos_r;
    rtop_nxt    = rtop_r;
    opnd_ok_nxt = opnd_ok_r;
    strobe_nxt  = 1'b0;
    rv_nxt      = rv_r;
    req_nxt     = req_r;
    pm_we       = 1'b0;
    pm_waddr    = in_address;
    pm_wdata    = in_value;
    pm_raddr    = ip_r[PM_AW-1:0];
    ds_we       = 1'b0;
    ds_waddr    = dp_r;
    ds_wdata    = top_r;
    ds_raddr    = dp_r;
    rs_we       = 1'b0;
    rs_waddr    = rp_inc;
    rs_wdata    = top_r;
    rs_raddr    = rp_r;
    div_req.start    = 1'b0;
    div_req.dividend = nos_r;
    div_req.divisor  = top_r;
    tgt  = ip_p1;
    jmp  = 1'b0;
    take = 1'b0;

    case (state_r)
      // return stack sweep after reset
      ST_CLEAR: begin
        rs_we    = 1'b1;
        rs_waddr = clr_r;
        rs_wdata = '0;
        clr_nxt  = clr_r + RP_W'(1);
        if (clr_r == RP_W'(RETURN_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // host transfer; reads of ip/dp/rp are already under way
      ST_IDLE: begin
        if (acc) begin
          rv_nxt  = '0;
          req_nxt = 1'b0;
          case (kind_t'(in_opcode))
            KIND_LOAD: begin
              pm_we      = 1'b1;
              strobe_nxt = 1'b1;
            end
            KIND_PWRITE: begin
              if (in_in_ports) begin
                port_nxt[in_pidx] = in_value;
              end
              strobe_nxt = 1'b1;
            end
            KIND_PREAD: begin
              if (in_in_ports) begin
                rv_nxt = port_r[in_pidx];
              end
              strobe_nxt = 1'b1;
            end
            KIND_EXEC: begin
              if (stopped_r) begin
                strobe_nxt = 1'b1;
              end else if (ip_r >= IP_W'(IMAGE_WORDS)) begin
                ip_nxt      = IP_W'(IMAGE_WORDS);
                stopped_nxt = 1'b1;
                strobe_nxt  = 1'b1;
              end else begin
                state_nxt = ST_OPND;
              end
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end

      // opcode, second and return top arrive; fetch operand and third
      ST_OPND: begin
        op_nxt     = pm_rdata[4:0];
        op_bad_nxt = (|pm_rdata[31:5]) || (pm_rdata[4:0] > OP_LAST);
        nos_nxt    = ds_rdata;
        rtop_nxt   = rs_rdata;
        ds_raddr   = dp_dec;
        if (pm_rdata == 32'(OP_FETCH)) begin
          pm_raddr    = top_r[PM_AW-1:0];
          opnd_ok_nxt = top_in_image;
        end else begin
          pm_raddr    = ip_p1[PM_AW-1:0];
          opnd_ok_nxt = (ip_p1 < IMAGE_WORDS);
        end
        state_nxt = ST_EXEC;
      end

      // execute and write back
      ST_EXEC: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
        if (op_bad_r) begin
          ip_nxt      = IP_W'(IMAGE_WORDS);
          stopped_nxt = 1'b1;
        end else begin
          jmp = 1'b1;
          case (op_t'(op_r))
            OP_NOP: ;
            OP_LIT: begin
              dp_nxt   = dp_inc;
              ds_we    = 1'b1;
              ds_waddr = dp_inc;
              top_nxt  = operand;
              tgt      = ip_p2;
            end
            OP_DUP: begin
              dp_nxt   = dp_inc;
              ds_we    = 1'b1;
              ds_waddr = dp_inc;
            end
            OP_DROP: begin
              top_nxt = nos_r;
              dp_nxt  = dp_dec;
            end
            OP_SWAP: begin
              ds_we   = 1'b1;
              top_nxt = nos_r;
            end
            OP_PUSH: begin
              rp_nxt  = rp_inc;
              rs_we   = 1'b1;
              top_nxt = nos_r;
              dp_nxt  = dp_dec;
            end
            OP_POP: begin
              dp_nxt   = dp_inc;
              ds_we    = 1'b1;
              ds_waddr = dp_inc;
              top_nxt  = rtop_r;
              rp_nxt   = rp_dec;
            end
            OP_CALL: begin
              rp_nxt   = rp_inc;
              rs_we    = 1'b1;
              rs_wdata = ip_p1;
              tgt      = operand;
            end
            OP_JUMP: tgt = operand;
            OP_RETURN: begin
              tgt    = rtop_r + 32'd1;
              rp_nxt = rp_dec;
            end
            OP_GT_JUMP, OP_LT_JUMP, OP_NE_JUMP, OP_EQ_JUMP: begin
              case (op_t'(op_r))
                OP_GT_JUMP: take = ($signed(nos_r) > $signed(top_r));
                OP_LT_JUMP: take = ($signed(top_r) > $signed(nos_r));
                OP_NE_JUMP: take = (nos_r != top_r);
                default:    take = (nos_r == top_r);
              endcase
              top_nxt = ds_rdata;
              dp_nxt  = dp_dec2;
              tgt     = take ? operand : ip_p2;
            end
            OP_FETCH: top_nxt = operand;
            OP_STORE: begin
              if (top_in_image) begin
                pm_we    = 1'b1;
                pm_waddr = top_r[PM_AW-1:0];
                pm_wdata = nos_r;
              end
              top_nxt = ds_rdata;
              dp_nxt  = dp_dec2;
            end
            OP_ADD: begin top_nxt = nos_r + top_r; dp_nxt = dp_dec; end
            OP_SUB: begin top_nxt = nos_r - top_r; dp_nxt = dp_dec; end
            OP_MUL: begin top_nxt = nos_r * top_r; dp_nxt = dp_dec; end
            OP_DIVMOD: begin
              if (top_r == '0) begin
                top_nxt  = '0;
                ds_we    = 1'b1;
                ds_wdata = nos_r;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = ST_DIV;
                strobe_nxt    = 1'b0;
                jmp           = 1'b0;
              end
            end
            OP_AND: begin top_nxt = nos_r & top_r; dp_nxt = dp_dec; end
            OP_OR:  begin top_nxt = nos_r | top_r; dp_nxt = dp_dec; end
            OP_XOR: begin top_nxt = nos_r ^ top_r; dp_nxt = dp_dec; end
            OP_SHL: begin
              top_nxt = nos_r << top_r[4:0];
              dp_nxt  = dp_dec;
            end
            OP_SHR: begin
              top_nxt = word_t'($signed(nos_r) >>> top_r[4:0]);
              dp_nxt  = dp_dec;
            end
            OP_ZERO_EXIT: begin
              if (top_r == '0) begin
                top_nxt = nos_r;
                dp_nxt  = dp_dec;
                tgt     = rtop_r + 32'd1;
                rp_nxt  = rp_dec;
              end
            end
            OP_INC: top_nxt = top_r + 32'd1;
            OP_DEC: top_nxt = top_r - 32'd1;
            OP_IN: begin
              if (top_in_ports) begin
                top_nxt            = port_r[top_pidx];
                port_nxt[top_pidx] = '0;
              end else begin
                top_nxt = '0;
              end
            end
            OP_OUT: begin
              port_nxt[PORT_CTRL] = '0;
              if (top_in_ports) begin
                port_nxt[top_pidx] = nos_r;
              end
              top_nxt = ds_rdata;
              dp_nxt  = dp_dec2;
            end
            OP_WAIT: begin
              if (!wait_busy) begin
                // console input pending
                if (port_r[PORT_CTRL] == '0 && port_r[PORT_KEY] == 32'd1) begin
                  req_nxt = 1'b1;
                end
                // console output
                if (port_r[PORT_CHAR] == 32'd1) begin
                  rv_nxt              = top_r;
                  top_nxt             = nos_r;
                  dp_nxt              = dp_dec;
                  port_nxt[PORT_CHAR] = '0;
                  port_nxt[PORT_CTRL] = 32'd1;
                  req_nxt             = 1'b1;
                end
                // image save
                if (port_r[PORT_SAVE] == 32'd1) begin
                  port_nxt[PORT_SAVE] = '0;
                  port_nxt[PORT_CTRL] = 32'd1;
                  req_nxt             = 1'b1;
                end
                // capability queries
                if (port_r[PORT_QUERY] == QRY_IMAGE) begin
                  port_nxt[PORT_QUERY] = 32'(IMAGE_WORDS);
                  port_nxt[PORT_CTRL]  = 32'd1;
                end
                if (port_r[PORT_QUERY] == QRY_NONE2 || port_r[PORT_QUERY] == QRY_NONE3 ||
                    port_r[PORT_QUERY] == QRY_NONE4) begin
                  port_nxt[PORT_QUERY] = '0;
                  port_nxt[PORT_CTRL]  = 32'd1;
                end
                if (port_r[PORT_QUERY] == QRY_DEPTH) begin
                  port_nxt[PORT_QUERY] = {{(32-DP_W){1'b0}}, dp_nxt};
                  port_nxt[PORT_CTRL]  = 32'd1;
                end
                if (port_r[PORT_QUERY] == QRY_RDEPTH) begin
                  port_nxt[PORT_QUERY] = {{(32-RP_W){1'b0}}, rp_r};
                  port_nxt[PORT_CTRL]  = 32'd1;
                end
              end
            end
            default: begin
              jmp         = 1'b0;
              ip_nxt      = IP_W'(IMAGE_WORDS);
              stopped_nxt = 1'b1;
            end
          endcase
        end
      end

      // wait for the divider, then write back quotient and remainder
      ST_DIV: begin
        if (div_rsp.done) begin
          top_nxt    = div_rsp.quot;
          ds_we      = 1'b1;
          ds_wdata   = div_rsp.rem;
          jmp        = 1'b1;
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // branch target resolution; leaving the image halts
    if (jmp) begin
      if (tgt < IMAGE_WORDS) begin
        ip_nxt = tgt[IP_W-1:0];
      end else begin
        ip_nxt      = IP_W'(IMAGE_WORDS);
        stopped_nxt = 1'b1;
      end
    end
  end

  // control and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      ip_r      <= '0;
      top_r     <= '0;
      dp_r      <= '0;
      rp_r      <= '0;
      stopped_r <= 1'b0;
      port_r    <= '{default: '0};
      clr_r     <= '0;
      strobe_r  <= 1'b0;
      rv_r      <= '0;
      req_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ip_r      <= ip_nxt;
      top_r     <= top_nxt;
      dp_r      <= dp_nxt;
      rp_r      <= rp_nxt;
      stopped_r <= stopped_nxt;
      port_r    <= port_nxt;
      clr_r     <= clr_nxt;
      strobe_r  <= strobe_nxt;
      rv_r      <= rv_nxt;
      req_r     <= req_nxt;
    end
  end

  // instruction latches
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    op_bad_r  <= op_bad_nxt;
    nos_r     <= nos_nxt;
    rtop_r    <= rtop_nxt;
    opnd_ok_r <= opnd_ok_nxt;
  end

  // memories and divider
  scpu_ram #(.AW(PM_AW), .DW(32)) u_pmem (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  scpu_dstack u_dstack (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ds_we),
    .waddr (ds_waddr),
    .wdata (ds_wdata),
    .raddr (ds_raddr),
    .rdata (ds_rdata)
  );

  scpu_ram #(.AW(RP_W), .DW(32)) u_rstack (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  scpu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // outputs
  assign out_valid         = strobe_r;
  assign out_read_value    = rv_r;
  assign out_instr_pointer = ip_r;
  assign out_halted        = stopped_r;
  assign out_data_depth    = dp_r;
  assign out_return_depth  = rp_r;
  assign out_io_request    = req_r;

  // checks
  a_halt_ip : assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> ip_r == IP_W'(IMAGE_WORDS))
    else $error("halted core with live instruction pointer");

  a_div_state : assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside divide wait");

  a_halted_exec : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_opcode == KIND_EXEC && stopped_r) |=> $stable(ip_r) && out_valid)
    else $error("execute on halted core changed state");

  a_no_result_clear : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid)
    else $error("result during return stack sweep");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack CPU step engine testbench
// Drives load, execute and port items through the start/busy command port.
// A behavioural model of the core predicts each strobed result. A directed
// table runs first. Random instruction sequences follow, each built so that
// it only executes program words already loaded and keeps the core running.
// The core is halted deliberately at the very end.
// ----------------------------------------------------------------------------
module testbench;
  import scpu_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned ITEMS_PER_PHASE = 350;
  localparam word_t MIN_WORD = 32'h8000_0000;
  localparam word_t MAX_WORD = 32'h7FFF_FFFF;

  typedef struct packed {
    word_t      rv;
    logic [12:0] ip;
    logic        halted;
    logic [6:0]  dp;
    logic [9:0]  rp;
    logic        io;
  } step_result_t;

  typedef struct packed {
    kind_t        kind;
    logic [11:0]  addr;
    word_t        val;
    logic         typed;
    step_result_t res;
  } tab_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [11:0] in_address;
  logic signed [31:0] in_value;
  logic        out_valid;
  logic signed [31:0] out_read_value;
  logic [12:0] out_instr_pointer;
  logic        out_halted;
  logic [6:0]  out_data_depth;
  logic [9:0]  out_return_depth;
  logic        out_io_request;

  stack_cpu_instruction_step dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_address(in_address), .in_value(in_value),
    .out_valid(out_valid), .out_read_value(out_read_value),
    .out_instr_pointer(out_instr_pointer), .out_halted(out_halted),
    .out_data_depth(out_data_depth), .out_return_depth(out_return_depth),
    .out_io_request(out_io_request)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the core state
  word_t       prog_mem [IMAGE_WORDS];
  bit          prog_loaded [IMAGE_WORDS];
  word_t       dstack [DATA_DEPTH];
  word_t       rstack [RETURN_DEPTH];
  word_t       ports [PORT_COUNT];
  word_t       cur_ip;
  word_t       tos;
  logic [6:0]  dptr;
  logic [9:0]  rptr;
  bit          core_stopped;

  step_result_t pending_results[$];
  int unsigned  fail_count;
  int unsigned  idle_pct;
  int unsigned  quiet_cycles;
  int unsigned  item_count;

  // Memory reads beyond the image give zero
  function automatic word_t fetch_word(word_t a);
    return (a < IMAGE_WORDS) ? prog_mem[a[11:0]] : '0;
  endfunction

  task automatic goto_ip(word_t a);
    if (a >= IMAGE_WORDS) begin
      cur_ip = IMAGE_WORDS;
      core_stopped = 1'b1;
    end else begin
      cur_ip = a;
    end
  endtask

  task automatic dpush();
    dptr = dptr + 7'd1;
    dstack[dptr] = tos;
  endtask

  task automatic dpop(output word_t v);
    v = dstack[dptr];
    dptr = dptr - 7'd1;
  endtask

  task automatic rpush(word_t v);
    rptr = rptr + 10'd1;
    rstack[rptr] = v;
  endtask

  task automatic rpop(output word_t v);
    v = rstack[rptr];
    rptr = rptr - 10'd1;
  endtask

  // One instruction at cur_ip
  task automatic run_instruction(output word_t outch, output bit req);
    word_t ip, nos, tmp, ret;
    op_t   op;
    bit    take;
    longint n, d, q, r;
    ip = cur_ip;
    nos = dstack[dptr];
    outch = '0;
    req = 1'b0;
    tmp = fetch_word(ip);
    if (tmp > OP_LAST) begin
      cur_ip = IMAGE_WORDS;
      core_stopped = 1'b1;
      return;
    end
    op = op_t'(tmp[4:0]);
    case (op)
      OP_NOP: goto_ip(ip + 1);
      OP_LIT: begin
        dpush(); tos = fetch_word(ip + 1); goto_ip(ip + 2);
      end
      OP_DUP: begin
        dpush(); goto_ip(ip + 1);
      end
      OP_DROP: begin
        dpop(tos); goto_ip(ip + 1);
      end
      OP_SWAP: begin
        dstack[dptr] = tos; tos = nos; goto_ip(ip + 1);
      end
      OP_PUSH: begin
        rpush(tos); dpop(tos); goto_ip(ip + 1);
      end
      OP_POP: begin
        dpush(); rpop(tos); goto_ip(ip + 1);
      end
      OP_CALL: begin
        rpush(ip + 1); goto_ip(fetch_word(ip + 1));
      end
      OP_JUMP: goto_ip(fetch_word(ip + 1));
      OP_RETURN: begin
        rpop(ret); goto_ip(ret + 1);
      end
      OP_GT_JUMP, OP_LT_JUMP, OP_NE_JUMP, OP_EQ_JUMP: begin
        case (op)
          OP_GT_JUMP: take = $signed(nos) > $signed(tos);
          OP_LT_JUMP: take = $signed(tos) > $signed(nos);
          OP_NE_JUMP: take = nos != tos;
          default:    take = nos == tos;
        endcase
        dpop(tmp); dpop(tos);
        goto_ip(take ? fetch_word(ip + 1) : ip + 2);
      end
      OP_FETCH: begin
        tos = fetch_word(tos); goto_ip(ip + 1);
      end
      OP_STORE: begin
        if (tos < IMAGE_WORDS) begin
          prog_mem[tos[11:0]] = nos;
          prog_loaded[tos[11:0]] = 1'b1;
        end
        dpop(tmp); dpop(tos); goto_ip(ip + 1);
      end
      OP_ADD: begin tos = nos + tos; dpop(tmp); goto_ip(ip + 1); end
      OP_SUB: begin tos = nos - tos; dpop(tmp); goto_ip(ip + 1); end
      OP_MUL: begin tos = nos * tos; dpop(tmp); goto_ip(ip + 1); end
      OP_DIVMOD: begin
        n = longint'($signed(nos));
        d = longint'($signed(tos));
        if (d == 0) begin
          q = 0; r = n;
        end else begin
          q = n / d; r = n % d;
        end
        tos = q[31:0];
        dstack[dptr] = r[31:0];
        goto_ip(ip + 1);
      end
      OP_AND: begin tos = nos & tos; dpop(tmp); goto_ip(ip + 1); end
      OP_OR:  begin tos = nos | tos; dpop(tmp); goto_ip(ip + 1); end
      OP_XOR: begin tos = nos ^ tos; dpop(tmp); goto_ip(ip + 1); end
      OP_SHL: begin tos = nos << tos[4:0]; dpop(tmp); goto_ip(ip + 1); end
      OP_SHR: begin tos = $signed(nos) >>> tos[4:0]; dpop(tmp); goto_ip(ip + 1); end
      OP_ZERO_EXIT: begin
        if (tos == 0) begin
          dpop(tos); rpop(ret); goto_ip(ret + 1);
        end else begin
          goto_ip(ip + 1);
        end
      end
      OP_INC: begin tos = tos + 1; goto_ip(ip + 1); end
      OP_DEC: begin tos = tos - 1; goto_ip(ip + 1); end
      OP_IN: begin
        tmp = tos;
        if (tmp < PORT_COUNT) begin
          tos = ports[tmp[3:0]]; ports[tmp[3:0]] = '0;
        end else begin
          tos = '0;
        end
        goto_ip(ip + 1);
      end
      OP_OUT: begin
        ports[PORT_CTRL] = '0;
        if (tos < PORT_COUNT) ports[tos[3:0]] = nos;
        dpop(tmp); dpop(tos); goto_ip(ip + 1);
      end
      default: begin
        // WAIT: host requests and capability queries
        if (ports[PORT_CTRL] != 1) begin
          if (ports[PORT_CTRL] == 0 && ports[PORT_KEY] == 1) req = 1'b1;
          if (ports[PORT_CHAR] == 1) begin
            outch = tos; dpop(tos);
            ports[PORT_CHAR] = '0; ports[PORT_CTRL] = 1; req = 1'b1;
          end
          if (ports[PORT_SAVE] == 1) begin
            ports[PORT_SAVE] = '0; ports[PORT_CTRL] = 1; req = 1'b1;
          end
          if (ports[PORT_QUERY] == QRY_IMAGE) begin
            ports[PORT_QUERY] = IMAGE_WORDS; ports[PORT_CTRL] = 1;
          end
          if (ports[PORT_QUERY] == QRY_NONE2 || ports[PORT_QUERY] == QRY_NONE3 ||
              ports[PORT_QUERY] == QRY_NONE4) begin
            ports[PORT_QUERY] = '0; ports[PORT_CTRL] = 1;
          end
          if (ports[PORT_QUERY] == QRY_DEPTH) begin
            ports[PORT_QUERY] = word_t'(dptr); ports[PORT_CTRL] = 1;
          end
          if (ports[PORT_QUERY] == QRY_RDEPTH) begin
            ports[PORT_QUERY] = word_t'(rptr); ports[PORT_CTRL] = 1;
          end
        end
        goto_ip(ip + 1);
      end
    endcase
  endtask

  // Apply one host item to the shadow state and return its result
  task automatic cpu_predict(kind_t kind, logic [11:0] addr, word_t val,
                             output step_result_t res);
    word_t rv;
    bit    req;
    rv = '0;
    req = 1'b0;
    case (kind)
      KIND_LOAD: begin
        prog_mem[addr] = val;
        prog_loaded[addr] = 1'b1;
      end
      KIND_EXEC: begin
        if (!core_stopped) begin
          if (cur_ip >= IMAGE_WORDS) begin
            cur_ip = IMAGE_WORDS;
            core_stopped = 1'b1;
          end else begin
            run_instruction(rv, req);
          end
        end
      end
      KIND_PWRITE: if (addr < PORT_COUNT) ports[addr[3:0]] = val;
      default:     if (addr < PORT_COUNT) rv = ports[addr[3:0]];
    endcase
    res.rv = rv;
    res.ip = cur_ip[12:0];
    res.halted = core_stopped;
    res.dp = dptr;
    res.rp = rptr;
    res.io = req;
  endtask

  // Would this opcode/operand pair send the core off the image?
  function automatic bit leaves_image(op_t op, word_t opnd);
    word_t nos, nxt;
    bit    take;
    nos = dstack[dptr];
    case (op)
      OP_LIT: nxt = cur_ip + 2;
      OP_CALL, OP_JUMP: nxt = opnd;
      OP_RETURN: nxt = rstack[rptr] + 1;
      OP_GT_JUMP, OP_LT_JUMP, OP_NE_JUMP, OP_EQ_JUMP: begin
        case (op)
          OP_GT_JUMP: take = $signed(nos) > $signed(tos);
          OP_LT_JUMP: take = $signed(tos) > $signed(nos);
          OP_NE_JUMP: take = nos != tos;
          default:    take = nos == tos;
        endcase
        nxt = take ? opnd : cur_ip + 2;
      end
      OP_ZERO_EXIT: nxt = (tos == 0) ? rstack[rptr] + 1 : cur_ip + 1;
      default: nxt = cur_ip + 1;
    endcase
    return nxt >= IMAGE_WORDS;
  endfunction

  function automatic bit has_operand(op_t op);
    return op inside {OP_LIT, OP_CALL, OP_JUMP, OP_GT_JUMP, OP_LT_JUMP,
                      OP_NE_JUMP, OP_EQ_JUMP};
  endfunction

  // Data values weighted towards the corners
  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return MIN_WORD;
      4: return MAX_WORD;
      5: return $urandom_range(0, 40);
      6: return -$urandom_range(1, 6);
      default: return $urandom;
    endcase
  endfunction

  // Random sender gaps, start dropped once per gap
  task automatic sender_gap();
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // One transfer on the command port, then its expected result
  task automatic run_item(kind_t kind, logic [11:0] addr, word_t val,
                          bit typed, step_result_t typed_res);
    step_result_t res;
    item_count++;
    sender_gap();
    start <= 1'b1;
    in_opcode <= kind;
    in_address <= addr;
    in_value <= val;
    do @(posedge clk); while (busy);
    cpu_predict(kind, addr, val, res);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic send(kind_t kind, logic [11:0] addr, word_t val);
    run_item(kind, addr, val, 1'b0, '0);
  endtask

  // Hold off until every result is back
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One well-formed instruction: place it at ip, then execute it
  task automatic random_instruction();
    op_t   op;
    word_t opnd, eff;
    int    tries;
    for (tries = 0; tries < 8; tries++) begin
      op = op_t'($urandom_range(0, OP_LAST));
      opnd = ($urandom_range(0, 1) != 0) ? word_t'($urandom_range(0, 63))
                                         : word_t'($urandom_range(0, IMAGE_WORDS - 1));
      if (op == OP_LIT) opnd = pick_word();
      eff = (cur_ip + 1 < IMAGE_WORDS) ? opnd : '0;
      if (!leaves_image(op, eff)) break;
    end
    if (tries == 8) begin
      op = OP_JUMP;
      opnd = '0;
    end
    send(KIND_LOAD, cur_ip[11:0], word_t'(op));
    if (has_operand(op) && cur_ip + 1 < IMAGE_WORDS)
      send(KIND_LOAD, cur_ip[11:0] + 12'd1, opnd);
    if (op == OP_FETCH && tos < IMAGE_WORDS && !prog_loaded[tos[11:0]])
      send(KIND_LOAD, tos[11:0], pick_word());
    send(KIND_EXEC, '0, $urandom);
  endtask

  // Result checking
  always @(posedge clk) begin
    step_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.rv) begin
          $error("read_value: expected %h, got %h", want.rv, out_read_value);
          fail_count++;
        end
        if (out_instr_pointer !== want.ip) begin
          $error("instr_pointer: expected %0d, got %0d", want.ip, out_instr_pointer);
          fail_count++;
        end
        if (out_halted !== want.halted) begin
          $error("halted: expected %0d, got %0d", want.halted, out_halted);
          fail_count++;
        end
        if (out_data_depth !== want.dp) begin
          $error("data_depth: expected %0d, got %0d", want.dp, out_data_depth);
          fail_count++;
        end
        if (out_return_depth !== want.rp) begin
          $error("return_depth: expected %0d, got %0d", want.rp, out_return_depth);
          fail_count++;
        end
        if (out_io_request !== want.io) begin
          $error("io_request: expected %0d, got %0d", want.io, out_io_request);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Directed table: port extremes, divide corners, capability query
  tab_row_t dir_tab [24];
  initial begin
    dir_tab = '{
      '{KIND_PREAD,  12'd0,    32'd0,       1'b1, '{32'd0, 13'd0, 1'b0, 7'd0, 10'd0, 1'b0}},
      '{KIND_PWRITE, 12'd15,   MAX_WORD,    1'b1, '{32'd0, 13'd0, 1'b0, 7'd0, 10'd0, 1'b0}},
      '{KIND_PREAD,  12'd15,   32'd0,       1'b1, '{MAX_WORD, 13'd0, 1'b0, 7'd0, 10'd0, 1'b0}},
      '{KIND_PWRITE, 12'd4095, 32'hFFFFFFFF, 1'b1, '{32'd0, 13'd0, 1'b0, 7'd0, 10'd0, 1'b0}},
      '{KIND_PREAD,  12'd4095, 32'd0,       1'b1, '{32'd0, 13'd0, 1'b0, 7'd0, 10'd0, 1'b0}},
      '{KIND_LOAD,   12'd4095, 32'd0,       1'b0, '0},
      '{KIND_LOAD,   12'd0,    32'(OP_LIT), 1'b0, '0},
      '{KIND_LOAD,   12'd1,    MIN_WORD,    1'b0, '0},
      '{KIND_LOAD,   12'd2,    32'(OP_LIT), 1'b0, '0},
      '{KIND_LOAD,   12'd3,    32'hFFFFFFFF, 1'b0, '0},
      '{KIND_LOAD,   12'd4,    32'(OP_DIVMOD), 1'b0, '0},
      '{KIND_LOAD,   12'd5,    32'(OP_LIT), 1'b0, '0},
      '{KIND_LOAD,   12'd6,    32'd0,       1'b0, '0},
      '{KIND_LOAD,   12'd7,    32'(OP_DIVMOD), 1'b0, '0},
      '{KIND_LOAD,   12'd8,    32'(OP_WAIT), 1'b0, '0},
      '{KIND_PWRITE, 12'd5,    QRY_IMAGE,   1'b0, '0},
      '{KIND_EXEC,   12'd0,    32'd0,       1'b0, '0},
      '{KIND_EXEC,   12'd0,    32'd0,       1'b0, '0},
      '{KIND_EXEC,   12'd0,    32'd0,       1'b0, '0},
      '{KIND_EXEC,   12'd0,    32'd0,       1'b0, '0},
      '{KIND_EXEC,   12'd0,    32'd0,       1'b0, '0},
      '{KIND_EXEC,   12'd0,    32'd0,       1'b0, '0},
      '{KIND_PREAD,  12'd5,    32'd0,       1'b1, '{32'd4096, 13'd9, 1'b0, 7'd3, 10'd0, 1'b0}},
      '{KIND_PREAD,  12'd0,    32'd0,       1'b1, '{32'd1, 13'd9, 1'b0, 7'd3, 10'd0, 1'b0}}
    };
  end

  // Stimulus
  initial begin
    int unsigned ph, sent;
    logic [11:0] pa;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = '0;
    in_address = '0;
    in_value = '0;
    fail_count = 0;
    quiet_cycles = 0;
    item_count = 0;
    idle_pct = 0;
    foreach (prog_mem[i]) begin
      prog_mem[i] = '0;
      prog_loaded[i] = 1'b0;
    end
    foreach (dstack[i]) dstack[i] = '0;
    foreach (rstack[i]) rstack[i] = '0;
    foreach (ports[i]) ports[i] = '0;
    cur_ip = '0;
    tos = '0;
    dptr = '0;
    rptr = '0;
    core_stopped = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      run_item(dir_tab[i].kind, dir_tab[i].addr, dir_tab[i].val,
               dir_tab[i].typed, dir_tab[i].res);

    // Random phases: no gaps, heavy gaps, light gaps
    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 1) ? 65 : (ph == 2) ? 7 : 0;
      drain();
      sent = item_count;
      while (item_count - sent < ITEMS_PER_PHASE) begin
        pa = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, PORT_COUNT - 1))
                                         : 12'($urandom);
        case ($urandom_range(0, 19))
          0, 1: send(KIND_PWRITE, pa, pick_word());
          2, 3: send(KIND_PREAD, pa, $urandom);
          4:    send(KIND_LOAD, 12'($urandom), $urandom);
          default: random_instruction();
        endcase
      end
    end

    // Halt on an undefined opcode, then execute while halted
    send(KIND_LOAD, cur_ip[11:0], word_t'(OP_LAST) + 1);
    send(KIND_EXEC, '0, '0);
    send(KIND_EXEC, '0, '0);
    send(KIND_PREAD, 12'(PORT_CTRL), '0);

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
